// ===== hdl/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros for the SHA-256 byte stream hasher.
// Used by the top level only; needs a clock and an active-low reset in scope.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// implication checked at every edge out of reset
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`endif

// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 byte stream hasher: types, constants, round functions.
// No dependencies.
`default_nettype none
package sha_pkg;
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    typedef logic [31:0] t_w32;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic t_w32 round_k(input logic [5:0] i);
        t_w32 k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_w32 rotr(input t_w32 v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ===== hdl/sha_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Depends on sha_pkg for payload types.
`default_nettype none
interface sha_in_if;
    logic                valid;
    logic                ready;
    sha_pkg::t_in_word   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    logic                valid;
    logic                ready;
    sha_pkg::t_out_word  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha_front.sv =====
// Front end: accepts input words, drops empty ones, queues them for the core.
// Depends on sha_pkg.
`default_nettype none
module sha_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  sha_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  wire                 i_pop,
    output sha_pkg::t_in_word   o_word
);
    sha_pkg::t_in_word r_mem [sha_pkg::QDepth];
    logic [sha_pkg::QAw-1:0] r_wp, r_rp;
    logic [sha_pkg::QAw:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (sha_pkg::QAw+1)'(sha_pkg::QDepth));
    assign push = i_valid && o_ready && (i_word.byte_present || i_word.message_end);
    assign pop = i_pop && o_valid;
    assign o_valid = (r_cnt != '0);
    assign o_word = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_word;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (sha_pkg::QAw+1)'(push) - (sha_pkg::QAw+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sha_core.sv =====
// Back end: block buffer, padding sequencer, 64-round compression, digest output.
// Depends on sha_pkg.
`default_nettype none
module sha_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  sha_pkg::t_in_word   i_word,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output sha_pkg::t_out_word  o_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2,
                           S_RND = 3'd3, S_FIN = 3'd4, S_OUT = 3'd5;

    logic [2:0]   r_st;
    logic [31:0]  r_buf [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [255:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh;
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [3:0]   r_ld;
    logic         r_final, r_pending_end, r_extra;
    logic [2:0]   r_oi;
    logic         r_ov;
    logic [31:0]  r_od;

    logic [31:0] ld_word, wt, t1, t2, s0, s1, wnew;
    assign ld_word = r_buf[r_ld];
    assign s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign wnew = s1 + r_w[9] + s0 + r_w[0];
    assign wt = r_w[0];
    assign t1 = r_hh + (sha_pkg::rotr(r_e, 6) ^ sha_pkg::rotr(r_e, 11) ^ sha_pkg::rotr(r_e, 25))
              + ((r_e & r_f) ^ (~r_e & r_g)) + sha_pkg::round_k(r_rnd) + wt;
    assign t2 = (sha_pkg::rotr(r_a, 2) ^ sha_pkg::rotr(r_a, 13) ^ sha_pkg::rotr(r_a, 22))
              + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    assign o_pop = (r_st == S_IDLE) && i_valid;
    assign o_valid = r_ov;
    assign o_word = '{digest_word: r_od, word_index: r_oi, last_word: (r_oi == 3'd7)};

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: if (i_valid && i_word.byte_present)
                r_buf[r_fill[5:2]][5'd31 - {r_fill[1:0], 3'd0} -: 8] <= i_word.data_byte;
            S_PAD: begin
                if (r_fill >= 6'd56 && r_final)
                    r_buf[r_fill[5:2]][5'd31 - {r_fill[1:0], 3'd0} -: 8] <=
                        r_bits[8'd63 - {2'd0, r_fill[2:0], 3'd0} -: 8];
                else if (r_pending_end)
                    r_buf[r_fill[5:2]][5'd31 - {r_fill[1:0], 3'd0} -: 8] <= 8'h80;
                else r_buf[r_fill[5:2]][5'd31 - {r_fill[1:0], 3'd0} -: 8] <= 8'h00;
            end
            S_LOAD: begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= ld_word;
            end
            S_RND: begin
                if (r_rnd < 6'd48) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= wnew;
                end else begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= r_w[0];
                end
                r_hh <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
            end
            default: ;
        endcase
        if (r_st == S_LOAD && r_ld == 4'd0)
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hh} <= r_h;

        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_bits <= '0; r_h <= sha_pkg::InitHash;
            r_rnd <= '0; r_ld <= '0; r_final <= 1'b0; r_pending_end <= 1'b0;
            r_extra <= 1'b0;
            r_oi <= '0; r_ov <= 1'b0; r_od <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    if (i_word.byte_present) begin
                        r_bits <= r_bits + 64'd8;
                        r_fill <= r_fill + 6'd1;
                    end
                    r_pending_end <= i_word.message_end;
                    if (i_word.byte_present && r_fill == 6'd63) begin
                        r_st <= S_LOAD; r_ld <= '0; r_final <= 1'b0;
                    end else if (i_word.message_end) begin
                        r_st <= S_PAD; r_final <= 1'b0;
                        if (i_word.byte_present) r_fill <= r_fill + 6'd1;
                    end
                end
                S_PAD: begin
                    r_pending_end <= 1'b0;
                    // no room left for the length: it goes in a second block
                    if (r_pending_end) r_extra <= (r_fill > 6'd55);
                    if ((r_pending_end && r_fill <= 6'd55) || (r_extra && r_fill == 6'd0))
                        r_final <= 1'b1;
                    if (r_extra && r_fill == 6'd0) r_extra <= 1'b0;
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        r_st <= S_LOAD; r_ld <= '0;
                    end
                end
                S_LOAD: begin
                    r_ld <= r_ld + 4'd1;
                    if (r_ld == 4'd15) begin r_st <= S_RND; r_rnd <= '0; end
                end
                S_RND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_st <= S_FIN;
                end
                S_FIN: begin
                    r_h <= {r_h[255:224] + r_a, r_h[223:192] + r_b, r_h[191:160] + r_c,
                            r_h[159:128] + r_d, r_h[127:96] + r_e, r_h[95:64] + r_f,
                            r_h[63:32] + r_g, r_h[31:0] + r_hh};
                    if (r_final) begin
                        r_st <= S_OUT; r_oi <= '0;
                    end else if (r_pending_end || r_extra) r_st <= S_PAD;
                    else r_st <= S_IDLE;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        if (r_ov && r_oi == 3'd7) begin
                            r_ov <= 1'b0; r_st <= S_IDLE; r_h <= sha_pkg::InitHash;
                            r_bits <= '0; r_fill <= '0; r_final <= 1'b0;
                        end else begin
                            r_ov <= 1'b1;
                            r_oi <= r_ov ? r_oi + 3'd1 : 3'd0;
                            r_od <= r_h[8'd255 - {(r_ov ? r_oi + 3'd1 : 3'd0), 5'd0} -: 32];
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: one byte per input word, an end flag, and eight digest
// words out. Each full block is loaded into the schedule, then runs 64 rounds of the
// single round unit and a fold; padding writes one byte a cycle. The core takes no
// new word meanwhile: words queue in a four-deep front queue. Depends on sha_pkg, sha_if.
`default_nettype none
`include "sha256_byte_stream_hasher_assert.svh"
module sha256_byte_stream_hasher (
    input  wire       i_clk,
    input  wire       i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    logic q_valid, q_pop;
    sha_pkg::t_in_word q_word;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_word(i_in.payload), .o_valid(q_valid), .i_pop(q_pop), .o_word(q_word));

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_word(q_word),
        .o_pop(q_pop), .o_valid(o_out.valid), .i_ready(o_out.ready), .o_word(o_out.payload));

    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_out.valid,
        o_out.payload.last_word == (o_out.payload.word_index == 3'd7))
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready,
        o_out.valid && $stable(o_out.payload))
    `SHA_ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, q_pop, q_valid)
endmodule
`default_nettype wire
